### rtl/wsts_pkg.sv
// Shared types and constants for the weighted sum-tree sampler.
`default_nettype none
package wsts_pkg;
  localparam int unsigned NODES = 1024;
  localparam int unsigned WEIGHT_BITS = 48;
  localparam int unsigned SUM_BITS = 58;
  localparam int unsigned IDX_BITS = $clog2(NODES);

  localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = {WEIGHT_BITS{1'b1}};

  typedef enum logic [0:0] {
    OP_UPDATE = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  // Multiply unit command and status.
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_cmd_t;

  typedef struct packed {
    logic         done;
    logic [127:0] product;
  } mul_rsp_t;
endpackage
`default_nettype wire

### rtl/weighted_sum_tree_sampler_unit.sv
// Top level of the weighted sum-tree sampler.
// The block holds an implicit binary tree of 1024 reaction weights; node i has
// children 2i+1 and 2i+2, and each node keeps its weight plus left and right
// subtree sums in one memory row. After reset a clearing pass writes zero into
// every row, one a cycle; no transaction is accepted then. One transaction is
// worked at a time through a small sequencer and a shared 64x64 multiplier
// that forms one 32x32 partial product per cycle. An update takes an accept
// step, the falling-factorial steps (one per factor plus one to switch species
// and one to finish), up to two multiplies (issue, four partial products, done
// flag), then a read, a wait and a write per row on the way to the root. Node
// 1023 sits ten levels down, so up to eleven rows are visited; a zero rate or
// no reactants skips the factorial and multiply steps. A search takes an accept
// step, a scaled draw on the multiplier and a read and a compare per level down
// the tree over at most eleven rows; an empty tree skips the draw and the
// descent. The memory's single read port sets the per-level cost. The result
// sits in an output register; the block takes no new transaction until it has
// been delivered. total_weight is kept in a register that tracks the root row,
// so it is valid for both kinds of transaction.
`default_nettype none
module weighted_sum_tree_sampler_unit
  import wsts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [0:0]  op,
  input  wire logic [9:0]  node_index,
  input  wire logic [31:0] rate,
  input  wire logic [15:0] amount_a,
  input  wire logic [1:0]  order_a,
  input  wire logic [15:0] amount_b,
  input  wire logic [1:0]  order_b,
  input  wire logic [31:0] draw,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [9:0]       chosen_index,
  output logic [57:0]      total_weight,
  output logic             empty_res,
  output logic             saturated
);
  typedef enum logic [12:0] {
    S_CLEAR  = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_FACT   = 13'b0000000000100,
    S_MUL    = 13'b0000000001000,
    S_MWAIT  = 13'b0000000010000,
    S_RD     = 13'b0000000100000,
    S_RWAIT  = 13'b0000001000000,
    S_WR     = 13'b0000010000000,
    S_SMUL   = 13'b0000100000000,
    S_SWAIT  = 13'b0001000000000,
    S_SRD    = 13'b0010000000000,
    S_SCMP   = 13'b0100000000000,
    S_DONE   = 13'b1000000000000
  } state_t;

  state_t state;

  // Transaction latches.
  logic [IDX_BITS-1:0]    idx;
  logic [31:0]            draw_r;
  logic [15:0]            amt_a;
  logic [15:0]            amt_b;
  logic [1:0]             ord_a;
  logic [1:0]             ord_b;
  logic [1:0]             fstep;     // factorial step index
  logic                   fsel;      // 0: species a, 1: species b
  logic [47:0]            fa;        // falling factorial of a (<2^48)
  logic [47:0]            fb;
  logic                   fzero;
  logic [1:0]             mstep;     // 0: rate*fa, 1: *fb
  logic [WEIGHT_BITS-1:0] w;
  logic                   sat;
  logic [WEIGHT_BITS:0]   delta;     // new minus old weight, signed
  logic                   first;     // first row visit carries the weight write
  logic                   from_left; // child we came up from
  logic [IDX_BITS-1:0]    cur;
  logic [SUM_BITS-1:0]    total;
  logic [SUM_BITS-1:0]    target;
  logic [SUM_BITS-1:0]    base;
  logic [IDX_BITS:0]      clr_cnt;

  // Memory connection.
  logic                   wr_en;
  logic [IDX_BITS-1:0]    wr_addr;
  logic [WEIGHT_BITS-1:0] wr_weight;
  logic [SUM_BITS-1:0]    wr_left;
  logic [SUM_BITS-1:0]    wr_right;
  logic [WEIGHT_BITS-1:0] rd_weight;
  logic [SUM_BITS-1:0]    rd_left;
  logic [SUM_BITS-1:0]    rd_right;

  mul_cmd_t mcmd;
  mul_rsp_t mrsp;

  wsts_mul u_mul (.clk(clk), .rst(rst), .cmd(mcmd), .rsp(mrsp));

  wsts_tree_mem u_mem (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_weight(wr_weight),
    .wr_left(wr_left), .wr_right(wr_right), .rd_addr(cur),
    .rd_weight(rd_weight), .rd_left(rd_left), .rd_right(rd_right)
  );

  // Factorial factor for this step; below zero means a zero factor.
  logic [15:0] f_amt;
  logic [1:0]  f_ord;
  logic [16:0] f_fac;
  logic [63:0] f_prod;
  always_comb begin
    f_amt = fsel ? amt_b : amt_a;
    f_ord = fsel ? ord_b : ord_a;
    f_fac = {1'b0, f_amt} - {15'd0, fstep};
    f_prod = (fsel ? {16'd0, fb} : {16'd0, fa}) * {48'd0, f_fac[15:0]};
  end

  // Saturation check on a finished product.
  logic prod_over;
  assign prod_over = |mrsp.product[127:WEIGHT_BITS];

  // Descent compares.
  logic [SUM_BITS-1:0] lo_edge;
  logic [SUM_BITS-1:0] hi_edge;
  logic [IDX_BITS+1:0] child_l;
  logic [IDX_BITS+1:0] child_r;
  always_comb begin
    lo_edge = base + rd_left;
    hi_edge = lo_edge + {{(SUM_BITS-WEIGHT_BITS){1'b0}}, rd_weight};
    child_l = {1'b0, cur, 1'b1};
    child_r = {1'b0, cur, 1'b0} + {{IDX_BITS{1'b0}}, 2'd2};
  end

  // Row write: zero during the clearing pass, else the updated row.
  logic [SUM_BITS-1:0] delta_ext;
  assign delta_ext = {{(SUM_BITS-WEIGHT_BITS-1){delta[WEIGHT_BITS]}}, delta};
  always_comb begin
    wr_en = 1'b0;
    wr_addr = cur;
    wr_weight = rd_weight;
    wr_left = rd_left;
    wr_right = rd_right;
    if (state == S_CLEAR) begin
      wr_en = 1'b1;
      wr_addr = clr_cnt[IDX_BITS-1:0];
      wr_weight = '0;
      wr_left = '0;
      wr_right = '0;
    end else if (state == S_WR) begin
      wr_en = 1'b1;
      if (first) wr_weight = w;
      else if (from_left) wr_left = rd_left + delta_ext;
      else wr_right = rd_right + delta_ext;
    end
  end

  always_comb begin
    mcmd.start = 1'b0;
    mcmd.a = {32'd0, rate};
    mcmd.b = '0;
    if (state == S_MUL) begin
      mcmd.start = 1'b1;
      mcmd.a = {16'd0, w};
      mcmd.b = (mstep == 2'd0) ? {16'd0, fa} : {16'd0, fb};
    end else if (state == S_SMUL) begin
      mcmd.start = 1'b1;
      mcmd.a = {32'd0, draw_r};
      mcmd.b = {6'd0, total};
    end
  end

  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_DONE);
  assign total_weight = total;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      total <= '0;
      cur <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + (IDX_BITS+1)'(1);
          if (clr_cnt == (IDX_BITS+1)'(NODES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            // Take the transaction and clear the result fields.
            amt_a <= amount_a;
            amt_b <= amount_b;
            ord_a <= order_a;
            ord_b <= order_b;
            draw_r <= draw;
            idx <= node_index[IDX_BITS-1:0];
            chosen_index <= '0;
            empty_res <= 1'b0;
            saturated <= 1'b0;
            fa <= 48'd1;
            fb <= 48'd1;
            fstep <= '0;
            fsel <= 1'b0;
            fzero <= 1'b0;
            sat <= 1'b0;
            mstep <= '0;
            base <= '0;
            if (op == OP_SEARCH) begin
              cur <= '0;
              if (total == '0) begin
                empty_res <= 1'b1;
                state <= S_DONE;
              end else begin
                state <= S_SMUL;
              end
            end else if ({6'd0, node_index} >= 16'(NODES)) begin
              state <= S_DONE;
            end else if (rate == 32'd0 || (order_a == 2'd0 && order_b == 2'd0)) begin
              w <= '0;
              cur <= node_index[IDX_BITS-1:0];
              first <= 1'b1;
              state <= S_RD;
            end else begin
              w <= WEIGHT_BITS'(rate);
              state <= S_FACT;
            end
          end
        end
        S_FACT: begin
          // Advance one factor of the falling factorial per cycle.
          if ({1'b0, fstep} < {1'b0, f_ord}) begin
            if (f_fac[16] || f_fac[15:0] == 16'd0) fzero <= 1'b1;
            if (fsel) fb <= f_prod[47:0];
            else fa <= f_prod[47:0];
            fstep <= fstep + 2'd1;
          end else if (!fsel) begin
            fsel <= 1'b1;
            fstep <= '0;
          end else if (fzero) begin
            w <= '0;
            cur <= idx;
            first <= 1'b1;
            state <= S_RD;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: state <= S_MWAIT;
        S_MWAIT: begin
          if (mrsp.done) begin
            if (prod_over || sat) begin
              w <= WEIGHT_MAX;
              sat <= 1'b1;
            end else begin
              w <= mrsp.product[WEIGHT_BITS-1:0];
            end
            if (mstep == 2'd1 || prod_over || sat) begin
              cur <= idx;
              first <= 1'b1;
              state <= S_RD;
            end else begin
              mstep <= mstep + 2'd1;
              state <= S_MUL;
            end
          end
        end
        S_RD: state <= S_RWAIT;
        S_RWAIT: begin
          if (first) delta <= {1'b0, w} - {1'b0, rd_weight};
          state <= S_WR;
        end
        S_WR: begin
          // Walk up: compute the parent and which side we came from.
          first <= 1'b0;
          if (cur == '0) begin
            saturated <= sat;
            total <= {{(SUM_BITS-WEIGHT_BITS){1'b0}}, wr_weight} + wr_left + wr_right;
            state <= S_DONE;
          end else begin
            from_left <= cur[0];
            cur <= (cur - IDX_BITS'(1)) >> 1;
            state <= S_RD;
          end
        end
        S_SMUL: state <= S_SWAIT;
        S_SWAIT: begin
          if (mrsp.done) begin
            target <= mrsp.product[SUM_BITS+31:32];
            state <= S_SRD;
          end
        end
        S_SRD: state <= S_SCMP;
        S_SCMP: begin
          // Descend one level or stop at this node.
          if (target < lo_edge) begin
            if (child_l >= (IDX_BITS+2)'(NODES)) begin
              chosen_index <= 10'(cur);
              state <= S_DONE;
            end else begin
              cur <= child_l[IDX_BITS-1:0];
              state <= S_SRD;
            end
          end else if (target >= hi_edge) begin
            if (child_r >= (IDX_BITS+2)'(NODES)) begin
              chosen_index <= 10'(cur);
              state <= S_DONE;
            end else begin
              base <= hi_edge;
              cur <= child_r[IDX_BITS-1:0];
              state <= S_SRD;
            end
          end else begin
            chosen_index <= 10'(cur);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // An empty search result never reports saturation.
  a_search_no_sat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && empty_res) |-> !saturated)
    else $error("empty search reported saturation");
  // Empty flag only with a zero total.
  a_empty_total: assert property (@(posedge clk) disable iff (rst)
    (out_valid && empty_res) |-> (total_weight == '0))
    else $error("empty flag with nonzero total");
  // No transaction is accepted during the clearing pass.
  a_clear_stall: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> in_stall)
    else $error("accept during clear");
endmodule
`default_nettype wire

### rtl/wsts_mul.sv
// Shared 64x64 multiplier built from one 32x32 partial product per cycle.
`default_nettype none
module wsts_mul
  import wsts_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire mul_cmd_t cmd,
  output mul_rsp_t      rsp
);
  logic [63:0]  a;
  logic [63:0]  b;
  logic [127:0] acc;
  logic [2:0]   step;
  logic         busy;
  logic         done;
  logic [31:0]  pa;
  logic [31:0]  pb;
  logic [63:0]  pp;
  logic [127:0] pp_shifted;

  // Select the partial product for this step: (i, j) = step bits.
  always_comb begin
    pa = step[1] ? a[63:32] : a[31:0];
    pb = step[0] ? b[63:32] : b[31:0];
    pp = pa * pb;
    pp_shifted = {64'd0, pp} << (7'd32 * (7'(step[1]) + 7'(step[0])));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        a <= cmd.a;
        b <= cmd.b;
        acc <= '0;
        step <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        acc <= acc + pp_shifted;
        if (step == 3'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 3'd1;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.product = acc;
endmodule
`default_nettype wire

### rtl/wsts_tree_mem.sv
// Tree storage: node weights and subtree sums; the clearing pass after reset is driven by the top level.
`default_nettype none
module wsts_tree_mem
  import wsts_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   wr_en,
  input  wire logic [IDX_BITS-1:0]    wr_addr,
  input  wire logic [WEIGHT_BITS-1:0] wr_weight,
  input  wire logic [SUM_BITS-1:0]    wr_left,
  input  wire logic [SUM_BITS-1:0]    wr_right,
  input  wire logic [IDX_BITS-1:0]    rd_addr,
  output logic [WEIGHT_BITS-1:0]      rd_weight,
  output logic [SUM_BITS-1:0]         rd_left,
  output logic [SUM_BITS-1:0]         rd_right
);
  logic [WEIGHT_BITS-1:0] weight_mem [NODES];
  logic [SUM_BITS-1:0]    left_mem [NODES];
  logic [SUM_BITS-1:0]    right_mem [NODES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      weight_mem[wr_addr] <= wr_weight;
      left_mem[wr_addr] <= wr_left;
      right_mem[wr_addr] <= wr_right;
    end
    rd_weight <= weight_mem[rd_addr];
    rd_left <= left_mem[rd_addr];
    rd_right <= right_mem[rd_addr];
  end
endmodule
`default_nettype wire

### sim/weighted_sum_tree_sampler_checker.sv
// Checker for the weighted sum-tree sampler: watches both channels and checks results.
`timescale 1ns / 100ps
module weighted_sum_tree_sampler_checker
  import wsts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [0:0]  op,
  input  wire logic [9:0]  node_index,
  input  wire logic [31:0] rate,
  input  wire logic [15:0] amount_a,
  input  wire logic [1:0]  order_a,
  input  wire logic [15:0] amount_b,
  input  wire logic [1:0]  order_b,
  input  wire logic [31:0] draw,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [9:0]  chosen_index,
  input  wire logic [57:0] total_weight,
  input  wire logic        empty_res,
  input  wire logic        saturated,
  output int               errors,
  output int               pending
);
  typedef struct packed {
    logic [9:0]  chosen;
    logic [57:0] total;
    logic        empty;
    logic        sat;
  } outcome_t;

  localparam logic [63:0] W_LIMIT = 64'(WEIGHT_MAX);

  logic [WEIGHT_BITS-1:0] weight_mem [NODES];
  logic [SUM_BITS-1:0]    left_sum   [NODES];
  logic [SUM_BITS-1:0]    right_sum  [NODES];
  outcome_t               outcome_q  [$];

  assign pending = outcome_q.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    errors++;
  endtask

  function automatic logic [63:0] falling_product(input logic [63:0] amt, input logic [1:0] ord);
    logic [63:0] p;
    p = 1;
    for (int i = 0; i < ord; i++) begin
      if (amt < i) return 0;
      p = p * (amt - i);
    end
    return p;
  endfunction

  function automatic logic [57:0] root_total();
    return 58'(weight_mem[0]) + left_sum[0] + right_sum[0];
  endfunction

  // Apply one transaction to the tree copy and return its outcome.
  function automatic outcome_t tree_step(input op_t kind, input int unsigned idx,
                                         input logic [63:0] r, input logic [63:0] aa,
                                         input logic [1:0] oa, input logic [63:0] ab,
                                         input logic [1:0] ob, input logic [63:0] u);
    outcome_t res;
    logic [63:0] w, fa, fb, tot, target, base, lo_edge, hi_edge;
    logic [57:0] delta;
    int unsigned cur, par, nxt;
    res = '0;
    if (kind == OP_UPDATE) begin
      w = 0;
      fa = falling_product(aa, oa);
      fb = falling_product(ab, ob);
      if ((oa != 0 || ob != 0) && r != 0 && fa != 0 && fb != 0) begin
        w = r;
        if (fa > W_LIMIT / w) begin
          res.sat = 1;
          w = W_LIMIT;
        end else w = w * fa;
        if (fb > W_LIMIT / w) begin
          res.sat = 1;
          w = W_LIMIT;
        end else w = w * fb;
      end
      delta = 58'(w) - 58'(weight_mem[idx]);
      weight_mem[idx] = w[WEIGHT_BITS-1:0];
      cur = idx;
      while (cur != 0) begin
        par = (cur - 1) / 2;
        if (cur == 2 * par + 1) left_sum[par] += delta;
        else right_sum[par] += delta;
        cur = par;
      end
    end else begin
      tot = 64'(root_total());
      if (tot == 0) res.empty = 1;
      else begin
        target = u * (tot >> 32) + ((u * tot[31:0]) >> 32);
        base = 0;
        cur = 0;
        forever begin
          lo_edge = base + 64'(left_sum[cur]);
          hi_edge = lo_edge + 64'(weight_mem[cur]);
          if (target < lo_edge) nxt = 2 * cur + 1;
          else if (target >= hi_edge) nxt = 2 * cur + 2;
          else break;
          if (nxt >= NODES) break;
          if (target >= hi_edge) base = hi_edge;
          cur = nxt;
        end
        res.chosen = cur[9:0];
      end
    end
    res.total = root_total();
    return res;
  endfunction

  initial errors = 0;

  always @(posedge clk) begin
    outcome_t want;
    outcome_t fresh;
    if (rst) begin
      for (int i = 0; i < NODES; i++) begin
        weight_mem[i] = '0;
        left_sum[i] = '0;
        right_sum[i] = '0;
      end
      outcome_q.delete();
    end else begin
      // Retire the result first; it always belongs to an earlier transaction.
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) report("unexpected result", 0, 0);
        else begin
          want = outcome_q.pop_front();
          if (chosen_index !== want.chosen) report("chosen_index", chosen_index, want.chosen);
          if (total_weight !== want.total) report("total_weight", total_weight, want.total);
          if (empty_res !== want.empty) report("empty_res", empty_res, want.empty);
          if (saturated !== want.sat) report("saturated", saturated, want.sat);
        end
      end
      if (in_valid && !in_stall) begin
        fresh = tree_step(op_t'(op), node_index, rate, amount_a, order_a,
                          amount_b, order_b, draw);
        outcome_q.insert(outcome_q.size(), fresh);
      end
    end
  end
endmodule

### sim/weighted_sum_tree_sampler_unit_tb.sv
// Testbench top for the weighted sum-tree sampler: stimulus, receiver and verdict.
`timescale 1ns / 100ps
module weighted_sum_tree_sampler_unit_tb;
  import wsts_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [0:0]  op;
  logic [9:0]  node_index;
  logic [31:0] rate;
  logic [15:0] amount_a;
  logic [1:0]  order_a;
  logic [15:0] amount_b;
  logic [1:0]  order_b;
  logic [31:0] draw;
  logic        out_valid;
  logic        out_stall;
  logic [9:0]  chosen_index;
  logic [57:0] total_weight;
  logic        empty_res;
  logic        saturated;
  int          errors;
  int          pending;
  int          hold_ask;      // count of long hold-offs asked of the receiver
  int          gap_left;      // idle cycles before the next transaction

  weighted_sum_tree_sampler_unit DUT (.*);

  weighted_sum_tree_sampler_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Bound the run: the clearing pass plus the slowest correct run, many times over.
  initial begin
    #8_000_000;
    $display("Verification failed");
    $finish;
  end

  // Receiver: switch among random stall patterns; honor a long hold-off on request.
  initial begin
    int mode;
    int served;
    served = 0;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      for (int c = 0; c < 64; c++) begin
        @(negedge clk);
        if (hold_ask != served) begin
          served = hold_ask;
          out_stall <= 1'b1;
          // hold for a counted stretch so the block fills and stalls its input
          repeat (300) @(negedge clk);
        end
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= c[3];
        endcase
      end
    end
  end

  // Offer one transaction at the falling edge and hold it until accepted.
  task automatic offer(input op_t kind, input logic [9:0] idx, input logic [31:0] r,
                       input logic [15:0] aa, input logic [1:0] oa,
                       input logic [15:0] ab, input logic [1:0] ob, input logic [31:0] u);
    @(negedge clk);
    if (gap_left > 0) begin
      in_valid <= 1'b0;
      repeat (gap_left) @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= kind;
    node_index <= idx;
    rate <= r;
    amount_a <= aa;
    order_a <= oa;
    amount_b <= ab;
    order_b <= ob;
    draw <= u;
    do @(posedge clk); while (in_stall);
    // Bursts of back-to-back transactions, separated by random gaps.
    gap_left = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 30) : 0;
  endtask

  // Drop valid and wait for every outstanding result.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_amount();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'($urandom_range(65000, 65535));
      default: return 16'($urandom_range(0, 12));
    endcase
  endfunction

  initial begin
    logic [31:0] r;
    rst = 1'b1;
    in_valid = 1'b0;
    hold_ask = 0;
    gap_left = 0;
    op = OP_UPDATE;
    node_index = '0;
    rate = '0;
    amount_a = '0;
    order_a = '0;
    amount_b = '0;
    order_b = '0;
    draw = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty tree, no reactants, too few molecules, saturation, edges.
    offer(OP_SEARCH, 10'd0, 32'd0, 16'd0, 2'd0, 16'd0, 2'd0, 32'hFFFF_FFFF);
    offer(OP_UPDATE, 10'd0, 32'hFFFF_FFFF, 16'd9, 2'd0, 16'd9, 2'd0, 32'd0);
    offer(OP_UPDATE, 10'd3, 32'h0001_0000, 16'd2, 2'd3, 16'd5, 2'd1, 32'd0);
    offer(OP_UPDATE, 10'd4, 32'h0001_0000, 16'd0, 2'd1, 16'd0, 2'd0, 32'd0);
    offer(OP_SEARCH, 10'd0, 32'd0, 16'd0, 2'd0, 16'd0, 2'd0, 32'd0);
    offer(OP_UPDATE, 10'd0, 32'h0003_8000, 16'd7, 2'd1, 16'd0, 2'd0, 32'd0);
    offer(OP_UPDATE, 10'd1023, 32'h0001_0000, 16'd5, 2'd2, 16'd4, 2'd1, 32'd0);
    offer(OP_UPDATE, 10'd511, 32'd1, 16'd3, 2'd3, 16'd3, 2'd3, 32'd0);
    offer(OP_UPDATE, 10'd2, 32'h0000_8000, 16'd1, 2'd1, 16'd1, 2'd0, 32'd0);
    offer(OP_SEARCH, 10'd0, 32'd0, 16'd0, 2'd0, 16'd0, 2'd0, 32'd0);
    offer(OP_SEARCH, 10'd0, 32'd0, 16'd0, 2'd0, 16'd0, 2'd0, 32'hFFFF_FFFF);
    offer(OP_SEARCH, 10'd0, 32'd0, 16'd0, 2'd0, 16'd0, 2'd0, 32'h8000_0000);
    offer(OP_UPDATE, 10'd600, 32'hFFFF_FFFF, 16'hFFFF, 2'd3, 16'hFFFF, 2'd3, 32'd0);
    offer(OP_UPDATE, 10'd700, 32'hFFFF_FFFF, 16'hFFFF, 2'd1, 16'd0, 2'd0, 32'd0);
    offer(OP_SEARCH, 10'd0, 32'd0, 16'd0, 2'd0, 16'd0, 2'd0, 32'h4000_0000);
    offer(OP_UPDATE, 10'd600, 32'd0, 16'hFFFF, 2'd3, 16'hFFFF, 2'd3, 32'd0);
    offer(OP_UPDATE, 10'd1022, 32'h0002_0000, 16'hFFFF, 2'd2, 16'd2, 2'd2, 32'd0);
    offer(OP_SEARCH, 10'd0, 32'd0, 16'd0, 2'd0, 16'd0, 2'd0, 32'hFFFF_FFFF);
    offer(OP_SEARCH, 10'd1023, 32'hFFFF_FFFF, 16'hFFFF, 2'd3, 16'hFFFF, 2'd3, 32'd1);

    // Pause until every expected result has come.
    drain();

    // Random: updates with mostly small counts, searches with full-range draws.
    for (int n = 0; n < 1550; n++) begin
      if (n == 400 || n == 1100) hold_ask++;
      if (n == 800) begin
        drain();
        gap_left = 0;
      end
      r = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 32'h0010_0000);
      offer(op_t'($urandom_range(0, 1)), 10'($urandom), r, pick_amount(),
            2'($urandom), pick_amount(), 2'($urandom), $urandom);
    end

    drain();
    repeat (100) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

### filelist.f
rtl/wsts_pkg.sv
rtl/wsts_mul.sv
rtl/wsts_tree_mem.sv
rtl/weighted_sum_tree_sampler_unit.sv
sim/weighted_sum_tree_sampler_checker.sv
sim/weighted_sum_tree_sampler_unit_tb.sv
